// ===== rtl/hdlc_pkg.sv =====
package hdlc_pkg;

	localparam int MAX_FLAGS = 24;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] FLAG_OCTET = 8'h7E;
	localparam logic [15:0] CRC_POLY = 16'h8408;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [2:0] STUFF_RUN = 3'd5;
	localparam logic [3:0] FLAG_LEN = 4'd8;

	localparam int CFG_AW = 4;
	localparam logic [1:0] REG_LEADING = 2'd0;
	localparam logic [1:0] REG_BETWEEN = 2'd1;
	localparam logic [1:0] REG_TRAILING = 2'd2;

	typedef struct packed {
		logic [4:0] lead_cnt;
		logic [7:0] octet;
		logic frame_end;
		logic [15:0] fcs;
		logic [4:0] close_cnt;
	} job_t;

	typedef struct packed {
		logic [9:0] bits;
		logic [3:0] len;
		logic [2:0] run;
	} stuffed_t;

	function automatic logic [4:0] clamp_flags(input logic [4:0] v);
		return (v > 5'(MAX_FLAGS)) ? 5'(MAX_FLAGS) : v;
	endfunction

	function automatic logic [15:0] crc_octet(input logic [15:0] c_in, input logic [7:0] octet);
		logic [15:0] c;
		c = c_in;
		for (int b = 0; b < 8; b++) begin
			c[0] = c[0] ^ octet[b];
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	function automatic stuffed_t stuff_octet(input logic [7:0] octet, input logic [2:0] run_in);
		stuffed_t r;
		r.bits = '0;
		r.len = '0;
		r.run = run_in;
		for (int b = 0; b < 8; b++) begin
			r.bits = r.bits | (10'(octet[b]) << r.len);
			r.len = r.len + 4'd1;
			r.run = octet[b] ? (r.run + 3'd1) : 3'd0;
			if (r.run == STUFF_RUN) begin
				r.len = r.len + 4'd1;
				r.run = 3'd0;
			end
		end
		return r;
	endfunction

endpackage

// ===== rtl/hdlc_queue.sv =====
module hdlc_queue #(
	parameter int DEPTH = hdlc_pkg::QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  hdlc_pkg::job_t wr_data,
	output logic rd_valid,
	input  logic rd_pop,
	output hdlc_pkg::job_t rd_data
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	hdlc_pkg::job_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic do_wr;
	logic do_rd;

	assign wr_ready = (count_q != CW'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data = mem_q[rd_ptr_q];
	assign do_wr = wr_valid && wr_ready;
	assign do_rd = rd_pop && rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ===== rtl/hdlc_front.sv =====
module hdlc_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [7:0] octet,
	input  logic frame_end,
	input  logic transmission_end,
	input  logic [4:0] leading_flag_count,
	input  logic [4:0] between_flag_count,
	input  logic [4:0] trailing_flag_count,
	output logic job_valid,
	input  logic job_ready,
	output hdlc_pkg::job_t job
);

	logic [15:0] check_q;
	logic started_q;
	logic [15:0] check_next;
	logic accept;

	assign in_ready = job_ready;
	assign accept = in_valid && job_ready;
	assign job_valid = accept;
	assign check_next = hdlc_pkg::crc_octet(check_q, octet);

	always_comb begin
		job.lead_cnt = started_q ? 5'd0 : hdlc_pkg::clamp_flags(leading_flag_count);
		job.octet = octet;
		job.frame_end = frame_end;
		job.fcs = ~check_next;
		if (!frame_end) begin
			job.close_cnt = 5'd0;
		end else if (transmission_end) begin
			job.close_cnt = hdlc_pkg::clamp_flags(trailing_flag_count);
		end else begin
			job.close_cnt = hdlc_pkg::clamp_flags(between_flag_count);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_q <= hdlc_pkg::CRC_INIT;
			started_q <= 1'b0;
		end else if (accept) begin
			check_q <= frame_end ? hdlc_pkg::CRC_INIT : check_next;
			started_q <= !(frame_end && transmission_end);
		end
	end

endmodule

// ===== rtl/hdlc_back.sv =====
module hdlc_back (
	input  logic clk,
	input  logic arst_n,
	input  logic job_valid,
	output logic job_pop,
	input  hdlc_pkg::job_t job,
	output logic out_valid,
	input  logic out_ready,
	output logic [9:0] chunk_bits,
	output logic [3:0] chunk_length,
	output logic last
);

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_LEAD = 3'd1;
	localparam logic [2:0] PH_DATA = 3'd2;
	localparam logic [2:0] PH_FCS_LO = 3'd3;
	localparam logic [2:0] PH_FCS_HI = 3'd4;
	localparam logic [2:0] PH_CLOSE = 3'd5;

	logic [2:0] phase_q;
	logic [4:0] cnt_q;
	logic [2:0] run_q;
	logic out_valid_q;
	logic [9:0] bits_q;
	logic [3:0] len_q;
	logic last_q;

	logic [2:0] cur_ph;
	logic [4:0] cur_cnt;
	logic [7:0] stuff_in;
	hdlc_pkg::stuffed_t st;
	logic emit;
	logic [2:0] ph_next;
	logic [4:0] cnt_next;
	logic [2:0] run_next;
	logic [9:0] bits_d;
	logic [3:0] len_d;
	logic last_d;
	logic done;

	assign emit = job_valid && (!out_valid_q || out_ready);
	assign job_pop = emit && done;

	assign cur_ph = (phase_q == PH_IDLE) ? ((job.lead_cnt != 5'd0) ? PH_LEAD : PH_DATA) : phase_q;
	assign cur_cnt = (phase_q == PH_IDLE) ? job.lead_cnt : cnt_q;

	always_comb begin
		case (cur_ph)
			PH_FCS_LO: stuff_in = job.fcs[7:0];
			PH_FCS_HI: stuff_in = job.fcs[15:8];
			default: stuff_in = job.octet;
		endcase
	end

	assign st = hdlc_pkg::stuff_octet(stuff_in, run_q);

	always_comb begin
		bits_d = {2'b00, hdlc_pkg::FLAG_OCTET};
		len_d = hdlc_pkg::FLAG_LEN;
		last_d = 1'b0;
		done = 1'b0;
		ph_next = cur_ph;
		cnt_next = cur_cnt;
		run_next = run_q;
		unique case (cur_ph)
			PH_LEAD: begin
				cnt_next = cur_cnt - 5'd1;
				if (cur_cnt == 5'd1) begin
					ph_next = PH_DATA;
				end
			end
			PH_DATA: begin
				bits_d = st.bits;
				len_d = st.len;
				run_next = st.run;
				if (job.frame_end) begin
					ph_next = PH_FCS_LO;
				end else begin
					last_d = 1'b1;
					done = 1'b1;
					ph_next = PH_IDLE;
				end
			end
			PH_FCS_LO: begin
				bits_d = st.bits;
				len_d = st.len;
				run_next = st.run;
				ph_next = PH_FCS_HI;
			end
			PH_FCS_HI: begin
				bits_d = st.bits;
				len_d = st.len;
				run_next = 3'd0;
				if (job.close_cnt == 5'd0) begin
					last_d = 1'b1;
					done = 1'b1;
					ph_next = PH_IDLE;
				end else begin
					ph_next = PH_CLOSE;
					cnt_next = job.close_cnt;
				end
			end
			PH_CLOSE: begin
				cnt_next = cur_cnt - 5'd1;
				if (cur_cnt == 5'd1) begin
					last_d = 1'b1;
					done = 1'b1;
					ph_next = PH_IDLE;
				end
			end
			default: begin
				ph_next = PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q <= '0;
			run_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				phase_q <= ph_next;
				cnt_q <= cnt_next;
				run_q <= run_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			bits_q <= bits_d;
			len_q <= len_d;
			last_q <= last_d;
		end
	end

	assign out_valid = out_valid_q;
	assign chunk_bits = bits_q;
	assign chunk_length = len_q;
	assign last = last_q;

endmodule

// ===== rtl/hdlc_bit_stuffing_framer.sv =====
// Channel   Direction  Contents
// s_axis    in         tdata[7:0] octet, tlast frame_end, tuser[0] transmission_end
// m_axis    out        tdata[9:0] chunk_bits, tdata[13:10] chunk_length, tlast last
// apb       in/out     flag count registers at byte addresses 0, 4 and 8
//
// The front accepts one request per cycle while the job queue has room.
// The back emits one chunk per cycle while the output is not stalled. A
// request yields one chunk for a plain octet, three plus the flags at a
// frame end, plus any leading flags. Reset clears the CRC, the stuffing run
// and the queue. Either side may stall without losing requests.
module hdlc_bit_stuffing_framer #(
	parameter int QUEUE_DEPTH = hdlc_pkg::QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [7:0] s_axis_tdata, // octet
	input  logic s_axis_tlast,
	input  logic [0:0] s_axis_tuser, // transmission_end
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [15:0] m_axis_tdata, // chunk_bits, chunk_length, zero fill
	output logic m_axis_tlast,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [hdlc_pkg::CFG_AW-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	logic [4:0] leading_q;
	logic [4:0] between_q;
	logic [4:0] trailing_q;
	logic cfg_wr;
	logic [1:0] reg_idx;

	logic job_valid;
	logic job_ready;
	hdlc_pkg::job_t job_in;
	logic head_valid;
	logic head_pop;
	hdlc_pkg::job_t head;
	logic [9:0] chunk_bits;
	logic [3:0] chunk_length;

	assign pready = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leading_q <= 5'd1;
			between_q <= 5'd1;
			trailing_q <= 5'd1;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				hdlc_pkg::REG_LEADING: leading_q <= pwdata[4:0];
				hdlc_pkg::REG_BETWEEN: between_q <= pwdata[4:0];
				hdlc_pkg::REG_TRAILING: trailing_q <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			hdlc_pkg::REG_LEADING: prdata = {27'd0, leading_q};
			hdlc_pkg::REG_BETWEEN: prdata = {27'd0, between_q};
			hdlc_pkg::REG_TRAILING: prdata = {27'd0, trailing_q};
			default: prdata = 32'd0;
		endcase
	end

	hdlc_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.octet(s_axis_tdata),
		.frame_end(s_axis_tlast),
		.transmission_end(s_axis_tuser[0]),
		.leading_flag_count(leading_q),
		.between_flag_count(between_q),
		.trailing_flag_count(trailing_q),
		.job_valid(job_valid),
		.job_ready(job_ready),
		.job(job_in)
	);

	hdlc_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_valid(job_valid),
		.wr_ready(job_ready),
		.wr_data(job_in),
		.rd_valid(head_valid),
		.rd_pop(head_pop),
		.rd_data(head)
	);

	hdlc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.job_valid(head_valid),
		.job_pop(head_pop),
		.job(head),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.chunk_bits(chunk_bits),
		.chunk_length(chunk_length),
		.last(m_axis_tlast)
	);

	assign m_axis_tdata = {2'b00, chunk_length, chunk_bits};

endmodule

// ===== bench/tb_hdlc_bit_stuffing_framer.sv =====
module tb_hdlc_bit_stuffing_framer;

	localparam int CLK_HALF = 2;
	localparam int LIMIT_CYCLES = 3000000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 20;
	localparam int PHASES = 6;
	localparam int PHASE_ITEMS = 82;
	localparam logic [15:0] X25_POLY = 16'h8408;
	localparam logic [15:0] X25_START = 16'hFFFF;
	localparam logic [7:0] FLAG_BYTE = 8'h7E;
	localparam logic [3:0] FLAG_BITS = 4'd8;
	localparam logic [4:0] FLAG_CAP = 5'd24;
	localparam logic [2:0] STUFF_AFTER = 3'd5;
	localparam logic [1:0] REG_NONE = 2'd3;

	typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

	typedef struct packed {
		logic [9:0] bits;
		logic [3:0] len;
		logic last;
	} chunk_t;

	typedef struct {
		bit known;
		int count;
		logic [9:0] bits;
		logic [3:0] len;
	} known_t;

	typedef struct {
		row_kind_t kind;
		logic [1:0] reg_idx;
		logic [31:0] value;
		logic [7:0] octet;
		bit fe;
		bit te;
		known_t want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata = '0; // octet
	logic s_axis_tlast = 1'b0;
	logic [0:0] s_axis_tuser = '0; // transmission_end
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata; // chunk_bits, chunk_length, zero fill
	logic m_axis_tlast;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [hdlc_pkg::CFG_AW-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	logic [4:0] lead_cfg = 5'd1;
	logic [4:0] between_cfg = 5'd1;
	logic [4:0] trail_cfg = 5'd1;
	logic [15:0] crc_state = X25_START;
	logic [2:0] stuff_run = 3'd0;
	bit tx_open = 1'b0;

	chunk_t chunks_due[$];
	known_t known_due[$];
	row_t rows[$];
	int mismatches = 0;
	bit calm = 1'b0;
	int holds_asked = 0;

	hdlc_bit_stuffing_framer u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	function automatic logic [4:0] flag_limit(input logic [4:0] v);
		return (v > FLAG_CAP) ? FLAG_CAP : v;
	endfunction

	function automatic logic [15:0] x25_next(input logic [15:0] c, input logic [7:0] octet);
		logic fb;
		for (int b = 0; b < 8; b++) begin
			fb = c[0] ^ octet[b];
			c = c >> 1;
			if (fb) begin
				c = c ^ X25_POLY;
			end
		end
		return c;
	endfunction

	// A zero goes in after every fifth one in a row; the run carries across octets.
	function automatic chunk_t stuffed_chunk(input logic [7:0] octet);
		chunk_t ch;
		int n;
		ch = '0;
		n = 0;
		for (int b = 0; b < 8; b++) begin
			ch.bits[n] = octet[b];
			n++;
			stuff_run = octet[b] ? stuff_run + 3'd1 : 3'd0;
			if (stuff_run == STUFF_AFTER) begin
				n++;
				stuff_run = 3'd0;
			end
		end
		ch.len = 4'(n);
		return ch;
	endfunction

	task automatic predict_chunks(input logic [7:0] octet, input bit fe, input bit te,
			output int count);
		chunk_t burst[$];
		chunk_t flag_ch;
		chunk_t ch;
		logic [15:0] fcs;
		flag_ch = '0;
		flag_ch.bits = 10'(FLAG_BYTE);
		flag_ch.len = FLAG_BITS;
		if (!tx_open) begin
			repeat (flag_limit(lead_cfg)) burst = {burst, flag_ch};
			tx_open = 1'b1;
		end
		crc_state = x25_next(crc_state, octet);
		burst = {burst, stuffed_chunk(octet)};
		if (fe) begin
			fcs = ~crc_state;
			burst = {burst, stuffed_chunk(fcs[7:0])};
			burst = {burst, stuffed_chunk(fcs[15:8])};
			repeat (flag_limit(te ? trail_cfg : between_cfg)) burst = {burst, flag_ch};
			crc_state = X25_START;
			stuff_run = 3'd0;
			if (te) begin
				tx_open = 1'b0;
			end
		end
		count = burst.size();
		foreach (burst[i]) begin
			ch = burst[i];
			ch.last = (i == burst.size() - 1);
			chunks_due = {chunks_due, ch};
		end
	endtask

	task automatic note_mismatch(input string what, input int got, input int want);
		mismatches++;
		$display("%0t: %s is %0h, expected %0h", $time, what, got, want);
	endtask

	task automatic row_req(input logic [7:0] octet, input bit fe, input bit te);
		row_t r;
		r = '{kind: ROW_REQ, reg_idx: 2'd0, value: 32'd0, octet: octet, fe: fe, te: te,
			want: '{known: 1'b0, count: 0, bits: 10'd0, len: 4'd0}};
		rows = {rows, r};
	endtask

	task automatic row_known(input logic [7:0] octet, input bit fe, input bit te,
			input int count, input logic [9:0] bits, input logic [3:0] len);
		row_t r;
		r = '{kind: ROW_REQ, reg_idx: 2'd0, value: 32'd0, octet: octet, fe: fe, te: te,
			want: '{known: 1'b1, count: count, bits: bits, len: len}};
		rows = {rows, r};
	endtask

	task automatic row_cfg(input logic [1:0] idx, input logic [31:0] value);
		row_t r;
		r = '{kind: ROW_CFG, reg_idx: idx, value: value, octet: 8'd0, fe: 1'b0, te: 1'b0,
			want: '{known: 1'b0, count: 0, bits: 10'd0, len: 4'd0}};
		rows = {rows, r};
	endtask

	task automatic send_request(input logic [7:0] octet, input bit fe, input bit te);
		if (!calm && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= octet;
		s_axis_tlast <= fe;
		s_axis_tuser <= te;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= hdlc_pkg::CFG_AW'({idx, 2'b00});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			hdlc_pkg::REG_LEADING: lead_cfg = value[4:0];
			hdlc_pkg::REG_BETWEEN: between_cfg = value[4:0];
			hdlc_pkg::REG_TRAILING: trail_cfg = value[4:0];
			default: ;
		endcase
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (chunks_due.size() != 0);
		@(posedge clk);
	endtask

	always @(posedge clk) begin : accept_side
		int count;
		known_t k;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			predict_chunks(s_axis_tdata, s_axis_tlast, s_axis_tuser[0], count);
			if (known_due.size() > 0) begin
				k = known_due.pop_front();
				if (k.known) begin
					if (count != k.count) begin
						note_mismatch("result count", count, k.count);
					end
					if (chunks_due[chunks_due.size() - 1].bits != k.bits) begin
						note_mismatch("final chunk_bits",
							int'(chunks_due[chunks_due.size() - 1].bits), int'(k.bits));
					end
					if (chunks_due[chunks_due.size() - 1].len != k.len) begin
						note_mismatch("final chunk_length",
							int'(chunks_due[chunks_due.size() - 1].len), int'(k.len));
					end
				end
			end
		end
	end

	always @(posedge clk) begin : result_side
		chunk_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (chunks_due.size() == 0) begin
				note_mismatch("unrequested chunk", int'(m_axis_tdata), 0);
			end else begin
				want = chunks_due.pop_front();
				if (m_axis_tdata[9:0] != want.bits) begin
					note_mismatch("chunk_bits", int'(m_axis_tdata[9:0]), int'(want.bits));
				end
				if (m_axis_tdata[13:10] != want.len) begin
					note_mismatch("chunk_length", int'(m_axis_tdata[13:10]), int'(want.len));
				end
				if (m_axis_tlast != want.last) begin
					note_mismatch("last", int'(m_axis_tlast), int'(want.last));
				end
			end
		end
	end

	// The long hold lets the job queue fill so that the input side stalls.
	initial begin : sink
		int hold_done;
		hold_done = 0;
		@(posedge clk);
		forever begin
			if (holds_asked != hold_done) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done++;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		int sent;
		int len;
		logic [7:0] octet;
		bit te;
		logic [4:0] lead;
		logic [4:0] betw;
		logic [4:0] trail;

		row_known(8'h00, 1'b0, 1'b0, 2, 10'h000, 4'd8);
		row_known(8'hFF, 1'b0, 1'b0, 1, 10'h1DF, 4'd9);
		row_known(8'hFF, 1'b0, 1'b0, 1, 10'h2FB, 4'd10);
		row_known(8'h7E, 1'b0, 1'b1, 1, 10'h0BE, 4'd9);
		row_known(8'h01, 1'b1, 1'b0, 4, 10'(FLAG_BYTE), FLAG_BITS);
		row_known(8'h80, 1'b1, 1'b1, 4, 10'(FLAG_BYTE), FLAG_BITS);
		row_known(8'h3C, 1'b1, 1'b1, 5, 10'(FLAG_BYTE), FLAG_BITS);
		row_cfg(hdlc_pkg::REG_LEADING, 32'd0);
		row_cfg(hdlc_pkg::REG_BETWEEN, 32'd0);
		row_cfg(hdlc_pkg::REG_TRAILING, 32'd0);
		row_known(8'h00, 1'b0, 1'b0, 1, 10'h000, 4'd8);
		row_req(8'hAA, 1'b1, 1'b0);
		row_req(8'h55, 1'b1, 1'b1);
		row_cfg(hdlc_pkg::REG_LEADING, 32'd31);
		row_cfg(hdlc_pkg::REG_BETWEEN, 32'd24);
		row_cfg(hdlc_pkg::REG_TRAILING, 32'hFFFF_FFF9);
		row_cfg(REG_NONE, 32'd0);
		row_known(8'hFF, 1'b0, 1'b0, 25, 10'h1DF, 4'd9);
		row_known(8'hF0, 1'b1, 1'b0, 27, 10'(FLAG_BYTE), FLAG_BITS);
		row_known(8'h0F, 1'b1, 1'b1, 27, 10'(FLAG_BYTE), FLAG_BITS);
		row_known(8'h12, 1'b1, 1'b1, 51, 10'(FLAG_BYTE), FLAG_BITS);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			if (rows[i].kind == ROW_CFG) begin
				wait_idle();
				apb_write(rows[i].reg_idx, rows[i].value);
			end else begin
				known_due = {known_due, rows[i].want};
				send_request(rows[i].octet, rows[i].fe, rows[i].te);
			end
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			wait_idle();
			case (phase)
				0: begin
					lead = 5'd0;
					betw = 5'd0;
					trail = 5'd0;
				end
				1: begin
					lead = 5'd24;
					betw = 5'd24;
					trail = 5'd24;
				end
				2: begin
					lead = 5'd31;
					betw = 5'd25;
					trail = 5'd31;
				end
				3: begin
					lead = 5'($urandom_range(0, 31));
					betw = 5'($urandom_range(0, 31));
					trail = 5'($urandom_range(0, 31));
				end
				default: begin
					lead = 5'($urandom_range(0, 3));
					betw = 5'($urandom_range(0, 3));
					trail = 5'($urandom_range(0, 3));
				end
			endcase
			calm = (phase == PHASES - 1);
			apb_write(hdlc_pkg::REG_LEADING, {27'($urandom), lead});
			apb_write(hdlc_pkg::REG_BETWEEN, {27'($urandom), betw});
			apb_write(hdlc_pkg::REG_TRAILING, {27'($urandom), trail});
			apb_write(REG_NONE, $urandom);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				if (phase == 1 && sent >= 10 && holds_asked == 0) begin
					holds_asked++;
				end
				if ($urandom_range(0, 9) == 0) begin
					send_request(8'($urandom), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)));
					sent++;
				end else begin
					len = $urandom_range(1, 8);
					for (int k = 0; k < len; k++) begin
						octet = ($urandom_range(0, 2) == 0) ?
							8'($urandom | $urandom | $urandom) : 8'($urandom);
						te = (k == len - 1) ? ($urandom_range(0, 2) == 0) :
							1'($urandom_range(0, 1));
						send_request(octet, k == len - 1, te);
						sent++;
					end
				end
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && chunks_due.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		#(LIMIT_CYCLES * 2 * CLK_HALF);
		$display("FAILED: results differ");
		$finish;
	end

endmodule
